>>> rtl/stps_pkg.sv
// ----------------------------------------------------------------------------
// Stud tile pixel shader package
// Shared constants, the blend mode type and the channel shading function.
// ----------------------------------------------------------------------------
package stps_pkg;

  localparam int DEF_MAX_STUD_SIZE = 64;
  localparam logic [6:0] RESET_SIZE = 7'd16;

  localparam logic [14:0] F_EDGE    = 15'd10158;
  localparam logic [14:0] F_RIM     = 15'd14418;
  localparam logic [14:0] F_KNOB    = 15'd19333;
  localparam logic [14:0] F_KSHADOW = 15'd13926;
  localparam logic [14:0] F_HILITE  = 15'd22118;
  localparam logic [14:0] TAN20_Q16 = 15'd23853;

  localparam int DEN_W        = 15;
  localparam int N_W          = 23;
  localparam int BLEND_STAGES = 9;

  typedef enum logic [1:0] {
    BM_KEEP,
    BM_FULL,
    BM_BLEND
  } blend_mode_t;

  function automatic logic [31:0] shade(input logic [31:0] c, input logic [14:0] f);
    logic [31:0] r;
    logic [22:0] p;
    r = {c[31:24], 24'b0};
    for (int i = 0; i < 3; i++) begin
      p = 23'(c[8*i +: 8]) * 23'(f);
      r[8*i +: 8] = (p[22:14] > 9'd255) ? 8'hFF : p[21:14];
    end
    return r;
  endfunction

endpackage

>>> rtl/stps_blend.sv
// ----------------------------------------------------------------------------
// Stud tile blend pipeline
// Weighted mix of two ARGB colours with an exact pipelined restoring divide,
// one quotient bit per stage, selected against keep and full replacement.
// ----------------------------------------------------------------------------
module stps_blend
  import stps_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                    clk,
  input  logic [BLEND_STAGES-1:0] en,
  input  blend_mode_t             mode,
  input  logic [31:0]             dst,
  input  logic [31:0]             src,
  input  logic [DEN_W-1:0]        num,
  input  logic [DEN_W-1:0]        den,
  input  logic [SIDE_W-1:0]       side_in,
  output logic [31:0]             color,
  output logic [SIDE_W-1:0]       side_out
);

  localparam int LAST = BLEND_STAGES - 1;

  logic [N_W-1:0]    rem  [BLEND_STAGES][4];
  logic [7:0]        quo  [BLEND_STAGES][4];
  blend_mode_t       md   [BLEND_STAGES];
  logic [31:0]       dq   [BLEND_STAGES];
  logic [31:0]       sq   [BLEND_STAGES];
  logic [DEN_W-1:0]  dn   [BLEND_STAGES];
  logic [SIDE_W-1:0] sd   [BLEND_STAGES];
  logic [N_W-1:0]    prod [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = N_W'(dst[8*c +: 8]) * N_W'(den - num) + N_W'(src[8*c +: 8]) * N_W'(num);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 4; c++) begin
        rem[0][c] <= prod[c];
        quo[0][c] <= '0;
      end
      md[0] <= mode;
      dq[0] <= dst;
      sq[0] <= src;
      dn[0] <= den;
      sd[0] <= side_in;
    end
  end

  for (genvar i = 1; i < BLEND_STAGES; i++) begin : g_step
    logic [N_W-1:0] trial;
    logic [3:0]     ge;

    always_comb begin
      trial = N_W'(dn[i-1]) << (BLEND_STAGES - 1 - i);
      for (int c = 0; c < 4; c++) begin
        ge[c] = rem[i-1][c] >= trial;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        for (int c = 0; c < 4; c++) begin
          rem[i][c] <= ge[c] ? rem[i-1][c] - trial : rem[i-1][c];
          quo[i][c] <= {quo[i-1][c][6:0], ge[c]};
        end
        md[i] <= md[i-1];
        dq[i] <= dq[i-1];
        sq[i] <= sq[i-1];
        dn[i] <= dn[i-1];
        sd[i] <= sd[i-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      case (md[LAST])
        BM_BLEND: color[8*c +: 8] = quo[LAST][c];
        BM_FULL:  color[8*c +: 8] = sq[LAST][8*c +: 8];
        default:  color[8*c +: 8] = dq[LAST][8*c +: 8];
      endcase
    end
  end

  assign side_out = sd[LAST];

endmodule

>>> rtl/stud_tile_pixel_shader.sv
// ----------------------------------------------------------------------------
// Stud tile pixel shader
// Shades one pixel of a square tile showing a single stud.
//
// Requests enter on in_valid/in_stall with base_color, local_x and local_y,
// and results leave on out_valid/out_stall as pixel_color, in order.
// The pipeline is 24 register stages deep, and one pixel is taken per cycle
// while nothing stalls. The depth is set by the two blends, each nine
// stages around an eight-step restoring divide.
// The tile size is written through cfg_valid/cfg_ready/stud_size. While a
// write is offered and in the cycle after it in_stall is held, so that the
// derived geometry is ready before the next request reaches it. The user
// must write the size only while the pipeline is empty; the block itself
// does not enforce it. Reset empties the pipeline and sets the size to 16.
// When the receiver stalls, stages behind the output keep filling until
// every stage holds a request, and only then is in_stall raised.
// ----------------------------------------------------------------------------
module stud_tile_pixel_shader
  import stps_pkg::*;
#(
  parameter int MAX_STUD_SIZE = DEF_MAX_STUD_SIZE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  stud_size,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] base_color,
  input  logic [5:0]  local_x,
  input  logic [5:0]  local_y,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] pixel_color
);

  localparam int L    = 6 + 2 * BLEND_STAGES;
  localparam int K_LO = 5;
  localparam int H_LO = K_LO + BLEND_STAGES;

  typedef struct packed {
    logic [6:0] s;
    logic [6:0] k;
  } geo1_t;

  typedef struct packed {
    logic [6:0] s;
    logic [6:0] k;
    logic [6:0] kx;
    logic [6:0] hbx;
    logic [6:0] hby;
    logic [6:0] aby;
    logic [6:0] hw;
    logic [6:0] ah;
  } geo2_t;

  typedef struct packed {
    logic [12:0] r2k;
    logic [12:0] r2h;
    logic [12:0] ah2;
  } geo3_t;

  typedef struct packed {
    logic [25:0]      wh;
    logic [DEN_W-1:0] denk;
    logic [DEN_W-1:0] denh;
    logic [19:0]      lim85k;
    logic [19:0]      lim85h;
  } geo4_t;

  typedef struct packed {
    logic             arc_hit;
    logic [31:0]      col_ks;
    logic [31:0]      col_h;
    blend_mode_t      mode_h;
    logic [DEN_W-1:0] num_h;
    logic             outside;
  } hl_side_t;

  function automatic geo1_t geo1(input logic [6:0] sz);
    geo1_t       r;
    logic [6:0]  ss;
    logic [8:0]  s3;
    logic [16:0] p;
    ss = sz;
    if (sz < 7'd4) begin
      ss = 7'd4;
    end else if (int'(sz) > MAX_STUD_SIZE) begin
      ss = 7'(MAX_STUD_SIZE);
    end
    s3 = 9'(ss) * 9'd3;
    p = 17'(s3) * 17'd205;
    r.s = ss;
    r.k = (p[16:10] < 7'd4) ? 7'd4 : p[16:10];
    return r;
  endfunction

  function automatic geo2_t geo2(input geo1_t g);
    geo2_t       r;
    logic [13:0] k3p;
    logic [14:0] k2p;
    logic [6:0]  k3;
    logic [6:0]  kx;
    k3p = 14'(g.k) * 14'd171;
    k2p = 15'({g.k, 1'b0}) * 15'd171;
    k3 = 7'(k3p[13:9]);
    kx = 7'((g.s - g.k) >> 1);
    r.s = g.s;
    r.k = g.k;
    r.kx = kx;
    r.hbx = kx + (g.k >> 2);
    r.hby = kx + (k3 >> 1);
    r.aby = kx + k3;
    r.hw = (k3 < 7'd2) ? 7'd2 : k3;
    r.ah = 7'(k2p[14:9]);
    return r;
  endfunction

  function automatic geo3_t geo3(input geo2_t g);
    geo3_t r;
    r.r2k = 13'(g.k) * 13'(g.k);
    r.r2h = 13'(g.hw) * 13'(g.hw);
    r.ah2 = 13'(g.ah) * 13'(g.ah);
    return r;
  endfunction

  function automatic geo4_t geo4(input geo3_t g);
    geo4_t r;
    r.wh = 26'(g.r2k) * 26'(g.ah2);
    r.denk = DEN_W'(g.r2k) * DEN_W'(3);
    r.denh = DEN_W'(g.r2h) * DEN_W'(3);
    r.lim85k = 20'(g.r2k) * 20'd85;
    r.lim85h = 20'(g.r2h) * 20'd85;
    return r;
  endfunction

  function automatic logic signed [9:0] offs(input logic [5:0] p, input logic [6:0] b,
                                             input logic [6:0] w);
    return $signed({3'b000, p, 1'b1}) - $signed({2'b00, b, 1'b0}) - $signed({3'b000, w});
  endfunction

  function automatic logic [15:0] sqr(input logic signed [9:0] a);
    logic signed [19:0] w;
    w = 20'(a);
    w = w * w;
    return w[15:0];
  endfunction

  logic [6:0] size_cfg;
  logic       cfg_settle;
  geo1_t g1;
  geo2_t g2;
  geo3_t g3;
  geo4_t g4;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_cfg <= RESET_SIZE;
      cfg_settle <= 1'b0;
      g1 <= geo1(RESET_SIZE);
      g2 <= geo2(geo1(RESET_SIZE));
      g3 <= geo3(geo2(geo1(RESET_SIZE)));
      g4 <= geo4(geo3(geo2(geo1(RESET_SIZE))));
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_cfg <= stud_size;
      end
      cfg_settle <= cfg_valid && cfg_ready;
      g1 <= geo1(size_cfg);
      g2 <= geo2(g1);
      g3 <= geo3(g2);
      g4 <= geo4(g3);
    end
  end

  assign cfg_ready = !rst;

  logic [L-1:0] v;
  logic [L-1:0] en;
  logic         in_take;

  always_comb begin
    en[L-1] = !v[L-1] || !out_stall;
    for (int i = L - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign in_stall  = rst || cfg_valid || cfg_settle || !en[0];
  assign in_take   = in_valid && !in_stall;
  assign out_valid = v[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= in_take;
      end
      for (int i = 1; i < L; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  logic [31:0] s0_base;
  logic [5:0]  s0_x;
  logic [5:0]  s0_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_base <= base_color;
      s0_x <= local_x;
      s0_y <= local_y;
    end
  end

  logic               s1_outside;
  logic [31:0]        s1_plate;
  logic [31:0]        s1_col_k;
  logic [31:0]        s1_col_ks;
  logic [31:0]        s1_col_h;
  logic signed [9:0]  s1_uk;
  logic signed [9:0]  s1_vk;
  logic signed [9:0]  s1_uh;
  logic signed [9:0]  s1_vh;
  logic signed [9:0]  s1_va;
  logic               edge_px;
  logic               rim_px;

  assign edge_px = (7'(s0_x) >= g2.s - 7'd2) || (7'(s0_y) >= g2.s - 7'd2);
  assign rim_px  = (s0_x == 6'd0) || (s0_y == 6'd0);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_outside <= (7'(s0_x) >= g2.s) || (7'(s0_y) >= g2.s);
      s1_plate <= edge_px ? shade(s0_base, F_EDGE) :
                  rim_px ? shade(s0_base, F_RIM) : s0_base;
      s1_col_k <= shade(s0_base, F_KNOB);
      s1_col_ks <= shade(s0_base, F_KSHADOW);
      s1_col_h <= shade(s0_base, F_HILITE);
      s1_uk <= offs(s0_x, g2.kx, g2.k);
      s1_vk <= offs(s0_y, g2.kx, g2.k);
      s1_uh <= offs(s0_x, g2.hbx, g2.hw);
      s1_vh <= offs(s0_y, g2.hby, g2.hw);
      s1_va <= offs(s0_y, g2.aby, g2.ah);
    end
  end

  logic        s2_outside;
  logic [31:0] s2_plate;
  logic [31:0] s2_col_k;
  logic [31:0] s2_col_ks;
  logic [31:0] s2_col_h;
  logic [16:0] s2_dk;
  logic [16:0] s2_dh;
  logic [15:0] s2_ua2;
  logic [15:0] s2_va2;
  logic        s2_tan_ok;
  logic [8:0]  au;
  logic [15:0] uk2;

  assign au  = s1_uk[9] ? 9'(-s1_uk) : 9'(s1_uk);
  assign uk2 = sqr(s1_uk);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_outside <= s1_outside;
      s2_plate <= s1_plate;
      s2_col_k <= s1_col_k;
      s2_col_ks <= s1_col_ks;
      s2_col_h <= s1_col_h;
      s2_dk <= 17'(uk2) + 17'(sqr(s1_vk));
      s2_dh <= 17'(sqr(s1_uh)) + 17'(sqr(s1_vh));
      s2_ua2 <= uk2;
      s2_va2 <= sqr(s1_va);
      s2_tan_ok <= (s1_va > 10'sd0) &&
                   ({s1_va[8:0], 16'b0} >= 25'(au) * 25'(TAN20_Q16));
    end
  end

  logic        s3_outside;
  logic [31:0] s3_plate;
  logic [31:0] s3_col_k;
  logic [31:0] s3_col_ks;
  logic [31:0] s3_col_h;
  logic [16:0] s3_dk;
  logic [16:0] s3_dh;
  logic [29:0] s3_pa;
  logic [29:0] s3_pb;
  logic        s3_tan_ok;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_outside <= s2_outside;
      s3_plate <= s2_plate;
      s3_col_k <= s2_col_k;
      s3_col_ks <= s2_col_ks;
      s3_col_h <= s2_col_h;
      s3_dk <= s2_dk;
      s3_dh <= s2_dh;
      s3_pa <= 30'(s2_ua2) * 30'(g3.ah2);
      s3_pb <= 30'(s2_va2) * 30'(g3.r2k);
      s3_tan_ok <= s2_tan_ok;
    end
  end

  blend_mode_t      mode_k;
  blend_mode_t      mode_h;
  logic [16:0]      diff_k;
  logic [16:0]      diff_h;
  logic [16:0]      num_k17;
  logic [16:0]      num_h17;
  blend_mode_t      s4_mode_k;
  logic [DEN_W-1:0] s4_num_k;
  logic [31:0]      s4_plate;
  logic [31:0]      s4_col_k;
  hl_side_t         s4_side;

  always_comb begin
    if (s3_dk > 17'(g3.r2k)) begin
      mode_k = BM_KEEP;
    end else if (24'(s3_dk) * 24'd100 <= 24'(g4.lim85k)) begin
      mode_k = BM_FULL;
    end else begin
      mode_k = BM_BLEND;
    end
    if (s3_dh > 17'(g3.r2h)) begin
      mode_h = BM_KEEP;
    end else if (24'(s3_dh) * 24'd100 <= 24'(g4.lim85h)) begin
      mode_h = BM_FULL;
    end else begin
      mode_h = BM_BLEND;
    end
    diff_k = 17'(g3.r2k) - s3_dk;
    diff_h = 17'(g3.r2h) - s3_dh;
    num_k17 = diff_k * 17'd20;
    num_h17 = diff_h * 17'd20;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_mode_k <= mode_k;
      s4_num_k <= num_k17[DEN_W-1:0];
      s4_plate <= s3_plate;
      s4_col_k <= s3_col_k;
      s4_side.arc_hit <= s3_tan_ok && (31'(s3_pa) + 31'(s3_pb) <= 31'(g4.wh));
      s4_side.col_ks <= s3_col_ks;
      s4_side.col_h <= s3_col_h;
      s4_side.mode_h <= mode_h;
      s4_side.num_h <= num_h17[DEN_W-1:0];
      s4_side.outside <= s3_outside;
    end
  end

  logic [31:0] k_color;
  hl_side_t    ks;
  logic [31:0] h_dst;
  logic [31:0] h_color;
  logic        h_outside;

  stps_blend #(
    .SIDE_W ($bits(hl_side_t))
  ) u_knob_blend (
    .clk      (clk),
    .en       (en[K_LO +: BLEND_STAGES]),
    .mode     (s4_mode_k),
    .dst      (s4_plate),
    .src      (s4_col_k),
    .num      (s4_num_k),
    .den      (g4.denk),
    .side_in  (s4_side),
    .color    (k_color),
    .side_out (ks)
  );

  assign h_dst = ks.arc_hit ? ks.col_ks : k_color;

  stps_blend #(
    .SIDE_W (1)
  ) u_hilite_blend (
    .clk      (clk),
    .en       (en[H_LO +: BLEND_STAGES]),
    .mode     (ks.mode_h),
    .dst      (h_dst),
    .src      (ks.col_h),
    .num      (ks.num_h),
    .den      (g4.denh),
    .side_in  (ks.outside),
    .color    (h_color),
    .side_out (h_outside)
  );

  always_ff @(posedge clk) begin
    if (en[L-1]) begin
      pixel_color <= h_outside ? 32'd0 : h_color;
    end
  end

endmodule

>>> sim/stud_tile_pixel_shader_tb.sv
// ----------------------------------------------------------------------------
// Stud tile pixel shader testbench
// Streams pixel requests through the shader under several tile sizes and
// random handshake idling, and checks each pixel against a local predictor.
// ----------------------------------------------------------------------------
module stud_tile_pixel_shader_tb
  import stps_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] color;
    logic [5:0]  x;
    logic [5:0]  y;
  } pixel_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  stud_size = 7'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] base_color = '0;
  logic [5:0]  local_x = '0;
  logic [5:0]  local_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] pixel_color;

  pixel_req_t    pending_reqs[$];
  logic [31:0]   expected_pixels[$];
  logic [6:0]    tile_size = RESET_SIZE;
  int            fail_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_cycles = 0;
  longint        cycle_count = 0;

  stud_tile_pixel_shader u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] scale_rgb(logic [31:0] c, longint f);
    logic [31:0] r;
    longint ch;
    r = {c[31:24], 24'b0};
    for (int i = 0; i < 3; i++) begin
      ch = (longint'(c[8*i +: 8]) * f) >>> 14;
      if (ch > 255) ch = 255;
      r[8*i +: 8] = ch[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] mix_argb(logic [31:0] d, logic [31:0] s,
                                           longint num, longint den);
    logic [31:0] r;
    longint ch;
    for (int i = 0; i < 4; i++) begin
      ch = (longint'(d[8*i +: 8]) * (den - num) + longint'(s[8*i +: 8]) * num) / den;
      r[8*i +: 8] = ch[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] paint_disc(logic [31:0] cur, logic [31:0] col,
      longint x, longint y, longint bx, longint by, longint w);
    longint u, v, dd, r2;
    u = 2 * (x - bx) + 1 - w;
    v = 2 * (y - by) + 1 - w;
    dd = u * u + v * v;
    r2 = w * w;
    if (dd > r2) return cur;
    if (100 * dd <= 85 * r2) return col;
    return mix_argb(cur, col, 20 * (r2 - dd), 3 * r2);
  endfunction

  function automatic bit in_shadow_arc(longint x, longint y, longint bx, longint by,
                                       longint w, longint h);
    longint u, v, au;
    u = 2 * (x - bx) + 1 - w;
    v = 2 * (y - by) + 1 - h;
    au = (u < 0) ? -u : u;
    if (u * u * h * h + v * v * w * w > w * w * h * h) return 1'b0;
    if (v <= 0) return 1'b0;
    return v * 65536 >= au * 23853;
  endfunction

  function automatic logic [31:0] shade_pixel(pixel_req_t r);
    longint s, x, y, k, kx, ky, hi;
    logic [31:0] px;
    s = tile_size;
    x = r.x;
    y = r.y;
    if (s < 4) s = 4;
    if (s > 64) s = 64;
    if (x >= s || y >= s) return 32'd0;
    if (x >= s - 2 || y >= s - 2) px = scale_rgb(r.color, 10158);
    else if (x == 0 || y == 0) px = scale_rgb(r.color, 14418);
    else px = r.color;
    k = (3 * s) / 5;
    if (k < 4) k = 4;
    kx = (s - k) / 2;
    ky = (s - k) / 2;
    px = paint_disc(px, scale_rgb(r.color, 19333), x, y, kx, ky, k);
    if (in_shadow_arc(x, y, kx, ky + k / 3, k, (2 * k) / 3))
      px = scale_rgb(r.color, 13926);
    hi = k / 3;
    if (hi < 2) hi = 2;
    return paint_disc(px, scale_rgb(r.color, 22118), x, y, kx + k / 4, ky + k / 6, hi);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_pixels.push_back(shade_pixel({base_color, local_x, local_y}));
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pixel_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        base_color <= r.color;
        local_x <= r.x;
        local_y <= r.y;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3000000) begin
      $display("stud_tile_pixel_shader regression: fail");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel_color: expected none, actual %h", pixel_color);
        fail_count <= fail_count + 1;
      end else begin
        logic [31:0] e;
        e = expected_pixels.pop_front();
        if (e !== pixel_color) begin
          $error("pixel_color: expected %h, actual %h", e, pixel_color);
          fail_count <= fail_count + 1;
        end
      end
    end
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [6:0] v);
    cfg_valid <= 1'b1;
    stud_size <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tile_size = v;
    repeat (8) @(posedge clk);
  endtask

  task automatic queue_req(logic [31:0] c, logic [5:0] x, logic [5:0] y);
    pending_reqs.push_back('{c, x, y});
  endtask

  task automatic queue_random(int n, logic [6:0] sz);
    int s;
    s = (sz < 4) ? 4 : ((sz > 64) ? 64 : sz);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        queue_req($urandom, 6'($urandom), 6'($urandom));
      else
        queue_req($urandom, 6'($urandom_range(s - 1)), 6'($urandom_range(s - 1)));
    end
  endtask

  initial begin
    logic [6:0] sizes[8];
    sizes = '{7'd16, 7'd4, 7'd64, 7'd0, 7'd127, 7'd5, 7'd23, 7'd40};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    queue_req(32'hFFFFFFFF, 6'd0, 6'd0);
    queue_req(32'h00000000, 6'd15, 6'd15);
    queue_req(32'h80FF8040, 6'd8, 6'd8);
    queue_req(32'h12345678, 6'd63, 6'd0);
    queue_req(32'hFFFFFFFF, 6'd16, 6'd3);
    queue_req(32'hA5C3E1F0, 6'd7, 6'd12);
    queue_req(32'h7FFFFFFF, 6'd14, 6'd1);
    queue_req(32'hFF808080, 6'd5, 6'd6);
    wait_drained();
    write_size(7'd64);
    queue_req(32'hFFFFFFFF, 6'd63, 6'd63);
    queue_req(32'h55AA55AA, 6'd32, 6'd32);
    queue_req(32'hAA55AA55, 6'd20, 6'd40);
    wait_drained();
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 28 : ((ph == 1) ? 64 : 0);
      recv_idle_pct = (ph == 0) ? 64 : ((ph == 1) ? 28 : 0);
      for (int j = 0; j < 8; j++) begin
        write_size(sizes[j]);
        queue_random(54, sizes[j]);
        if (ph == 2 && j == 0) hold_cycles = 200;
        wait_drained();
      end
    end
    if (fail_count == 0) begin
      $display("stud_tile_pixel_shader regression: pass");
    end else begin
      $display("stud_tile_pixel_shader regression: fail");
    end
    $finish;
  end
endmodule
